// ----- rtl/core/psr_pkg.sv -----
// Shared types and constants for the prime step register.
package psr_pkg;

    localparam int unsigned FIELD_W = 16;

    // Command codes; code 3 is unused and leaves the value as it is.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_NEXT = 2'd1;
    localparam logic [1:0] CMD_PREV = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] load_value;
    } cmd_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] old_value;
        logic [FIELD_W-1:0] new_value;
        logic               overflow;
    } res_item_t;

    // Status of the remainder unit.
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder ready
        logic zero;   // remainder is zero, valid with done
    } mod_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_SQ,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/core/psr_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one command item.
interface psr_cmd_if import psr_pkg::*;;
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/psr_res_if.sv -----
// Result channel: valid/ready handshake carrying one result item.
interface psr_res_if import psr_pkg::*;;
    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/psr_mod_unit.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module psr_mod_unit import psr_pkg::*;
#(
    parameter int unsigned WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output mod_stat_t        stat
);

    localparam int unsigned CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] shift_reg, shift_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    assign trial = {rem_reg, shift_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(WIDTH);
            rem_next   = '0;
            shift_next = dividend;
        end
        else if (busy_reg)
        begin
            // trial < 2*divisor, so one subtract restores the remainder
            if (trial >= {1'b0, divisor})
                rem_next = diff[WIDTH-1:0];
            else
                rem_next = trial[WIDTH-1:0];
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

// ----- rtl/core/prime_step_register.sv -----
// Prime step register: holds a prime (or 1), loads, steps to next/previous prime.
// Latency: data dependent. Each trial divisor runs a start step, one shift per dividend bit
//   and a done step; a candidate is tested, then runs divisors 2,3,5,7,9,... while d*d <= c.
// Throughput: one command at a time; ready is high only in the idle state.
//   A finished result sits in the output register while the next command is taken.
// Reset: asynchronous, active low; the held value returns to 1, no result pending.
module prime_step_register import psr_pkg::*;
#(
    parameter int unsigned WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    psr_cmd_if.sink   cmd_ch,
    psr_res_if.source res_ch
);

    localparam int unsigned LW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
    localparam int unsigned SW = WIDTH + 2;   // square of divisor may pass c

    localparam logic [WIDTH-1:0] MASK = {WIDTH{1'b1}};

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] cur_reg, cur_next;       // held value
    logic [WIDTH-1:0] old_reg, old_next;       // value before the command
    logic [WIDTH-1:0] cand_reg, cand_next;     // candidate, later the new value
    logic [WIDTH-1:0] d_reg, d_next;           // trial divisor
    logic [SW-1:0]    sq_reg, sq_next;         // d*d, kept by additions
    logic [1:0]       cmd_reg, cmd_next;
    logic             ovf_reg, ovf_next;

    logic             res_valid_reg, res_valid_next;
    res_item_t        res_reg, res_next;

    logic [WIDTH-1:0] lv_fit;
    logic             unit_start;
    mod_stat_t        unit_stat;
    logic             is_comp;
    logic             is_prime;

    assign lv_fit = WIDTH'(cmd_ch.data.load_value[LW-1:0]);

    psr_mod_unit #(
        .WIDTH (WIDTH)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .stat     (unit_stat)
    );

    // Sequencer: pick candidate, walk divisors, step candidate on failure.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        old_next       = old_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        cmd_next       = cmd_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        unit_start     = 1'b0;
        is_comp        = 1'b0;
        is_prime       = 1'b0;
        cmd_ch.ready   = (state_reg == ST_IDLE);

        if (res_valid_reg && res_ch.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    old_next = cur_reg;
                    cmd_next = cmd_ch.data.command;
                    ovf_next = 1'b0;
                    unique case (cmd_ch.data.command)
                        CMD_LOAD:
                        begin
                            cand_next  = lv_fit;
                            state_next = ST_TEST;
                        end
                        CMD_NEXT:
                        begin
                            if (cur_reg == MASK)
                            begin
                                // nothing larger fits: keep value, flag it
                                cand_next  = cur_reg;
                                ovf_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                cand_next  = cur_reg + WIDTH'(1);
                                state_next = ST_TEST;
                            end
                        end
                        CMD_PREV:
                        begin
                            if (cur_reg <= WIDTH'(3))
                            begin
                                cand_next  = WIDTH'(2);
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                cand_next  = cur_reg - WIDTH'(1);
                                state_next = ST_TEST;
                            end
                        end
                        default:
                        begin
                            cand_next  = cur_reg;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_TEST:
            begin
                if (cand_reg <= WIDTH'(1))
                    is_comp = 1'b1;
                else
                begin
                    d_next     = WIDTH'(2);
                    sq_next    = SW'(4);
                    state_next = ST_SQ;
                end
            end

            ST_SQ:
            begin
                if (sq_reg > {2'b00, cand_reg})
                    is_prime = 1'b1;
                else
                begin
                    unit_start = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (unit_stat.done)
                begin
                    if (unit_stat.zero)
                        is_comp = 1'b1;
                    else
                    begin
                        // after 2 only odd divisors: (d+2)^2 = d^2 + 4d + 4
                        if (d_reg == WIDTH'(2))
                        begin
                            d_next  = WIDTH'(3);
                            sq_next = SW'(9);
                        end
                        else
                        begin
                            d_next  = d_reg + WIDTH'(2);
                            sq_next = sq_reg + ({2'b00, d_reg} << 2) + SW'(4);
                        end
                        state_next = ST_SQ;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!res_valid_reg || res_ch.ready)
                begin
                    res_valid_next     = 1'b1;
                    res_next.old_value = FIELD_W'(old_reg[LW-1:0]);
                    res_next.new_value = FIELD_W'(cand_reg[LW-1:0]);
                    res_next.overflow  = ovf_reg;
                    cur_next           = cand_reg;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (is_prime)
            state_next = ST_FINISH;

        if (is_comp)
        begin
            case (cmd_reg)
                CMD_LOAD:
                begin
                    cand_next  = WIDTH'(1);
                    state_next = ST_FINISH;
                end
                CMD_NEXT:
                begin
                    if (cand_reg == MASK)
                    begin
                        cand_next  = old_reg;
                        ovf_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cand_next  = cand_reg + WIDTH'(1);
                        state_next = ST_TEST;
                    end
                end
                default:
                begin
                    // step down; 2 is prime so the walk stops there at the latest
                    cand_next  = cand_reg - WIDTH'(1);
                    state_next = ST_TEST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= WIDTH'(1);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_reg  <= old_next;
        cand_reg <= cand_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        cmd_reg  <= cmd_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
    end

    assign res_ch.valid = res_valid_reg;
    assign res_ch.data  = res_reg;

    // The held value is never zero: reset gives 1, every update a prime or 1.
    a_cur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg != '0)
        else $error("held value became zero");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ch.valid && cmd_ch.ready) |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // Overflow keeps the value.
    a_ovf_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.data.overflow) |->
            (res_ch.data.new_value == res_ch.data.old_value))
        else $error("overflow result changed the value");

    // Trial division only with divisors of two or more.
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ || state_reg == ST_DIV) |-> (d_reg >= WIDTH'(2)))
        else $error("trial divisor below two");

    // The remainder unit reports only while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        unit_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder ready outside the divide state");

endmodule

// ----- tb/tb_prime_step_register.sv -----
// Self-checking testbench for the prime step register: directed table plus random commands.
`timescale 1ns / 100ps

module tb_prime_step_register;
    import psr_pkg::*;

    localparam int unsigned WIDTH        = 16;
    localparam int unsigned VALUE_MASK   = (32'd1 << WIDTH) - 1;
    localparam int          DIRECTED_N   = 22;
    localparam int          RANDOM_ITEMS = 280;
    localparam int          QUIET_TAIL   = 40;
    // The worst steps lie near the top of the range; the limit leaves plenty of room.
    localparam int unsigned CYCLE_LIMIT  = 40_000_000;
    localparam int          MAX_REPORTS  = 10;

    // Code 3 has no name in the package: it leaves the value alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One row of the directed table. When 'typed' is set the answer below is
    // the one to check; otherwise the answer comes from the predictor.
    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] load_value;
        logic               typed;
        res_item_t          answer;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    psr_cmd_if cmd_ch ();
    psr_res_if res_ch ();

    prime_step_register #(.WIDTH(WIDTH)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    always #2 clk = ~clk;

    // Predictor state: the value the register should hold right now.
    int unsigned   held_value = 1;
    res_item_t     step_answers [$];
    int            mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int            stall_left = 0;
    bit            tail_quiet = 1'b0;
    directed_row_t directed_rows [DIRECTED_N];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Trial division, divisors 2, 3, 4, ... while d*d <= n.
    function automatic bit is_prime_value(input int unsigned n);
        int unsigned d;
        if (n <= 1)
            return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one command to held_value and returns the answer it produces.
    function automatic res_item_t apply_prime_command(input cmd_item_t item);
        res_item_t   ans;
        int unsigned cand;
        int unsigned lv;
        lv = item.load_value & VALUE_MASK;
        ans.old_value = FIELD_W'(held_value);
        ans.new_value = FIELD_W'(held_value);
        ans.overflow  = 1'b0;
        case (item.command)
            CMD_LOAD:
            begin
                ans.new_value = is_prime_value(lv) ? FIELD_W'(lv) : FIELD_W'(1);
            end
            CMD_NEXT:
            begin
                // assume overflow until a larger prime turns up
                cand = held_value;
                ans.overflow = 1'b1;
                while (cand < VALUE_MASK)
                begin
                    cand++;
                    if (is_prime_value(cand))
                    begin
                        ans.new_value = FIELD_W'(cand);
                        ans.overflow  = 1'b0;
                        break;
                    end
                end
            end
            CMD_PREV:
            begin
                // from 3 or below the search falls through to 2
                cand = held_value;
                ans.new_value = FIELD_W'(2);
                while (cand > 2)
                begin
                    cand--;
                    if (is_prime_value(cand))
                    begin
                        ans.new_value = FIELD_W'(cand);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        held_value = ans.new_value & VALUE_MASK;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (step_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: old=%0d new=%0d ovf=%0b",
                             $realtime, res_ch.data.old_value, res_ch.data.new_value,
                             res_ch.data.overflow);
            end
            else
            begin
                if (res_ch.data.old_value !== step_answers[0].old_value ||
                    res_ch.data.new_value !== step_answers[0].new_value ||
                    res_ch.data.overflow  !== step_answers[0].overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch: want old=%0d new=%0d ovf=%0b",
                                 $realtime, step_answers[0].old_value,
                                 step_answers[0].new_value, step_answers[0].overflow);
                        $display("%0t:           got  old=%0d new=%0d ovf=%0b",
                                 $realtime, res_ch.data.old_value,
                                 res_ch.data.new_value, res_ch.data.overflow);
                    end
                end
                void'(step_answers.pop_front());
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL prime_step_register");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: random stall bursts, none in the tail.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!tail_quiet && $urandom_range(0, 5) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= int'($urandom_range(1, 14)) - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after acceptance.
    // The answer is predicted at the accepting edge so the state stays in order.
    task automatic drive_command(input cmd_item_t item, input bit typed,
                                 input res_item_t typed_ans);
        res_item_t predicted;
        if (!tail_quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= item;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = apply_prime_command(item);
        step_answers.push_back(typed ? typed_ans : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        int        i;
        int        pick;
        cmd_item_t item;

        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rst_n        = 1'b0;

        // Directed walk: reset value, the 1/2/3 corner, loads of the extremes,
        // overflow at the largest 16-bit prime, the unused code, then a few
        // ordinary rows left to the predictor.
        directed_rows = '{
            '{CMD_UNUSED, 16'h0000, 1'b1, '{16'd1,     16'd1,     1'b0}}, // fresh after reset
            '{CMD_PREV,   16'h0000, 1'b1, '{16'd1,     16'd2,     1'b0}}, // down from 1
            '{CMD_PREV,   16'h0000, 1'b1, '{16'd2,     16'd2,     1'b0}}, // down from 2
            '{CMD_NEXT,   16'h0000, 1'b1, '{16'd2,     16'd3,     1'b0}},
            '{CMD_PREV,   16'hFFFF, 1'b1, '{16'd3,     16'd2,     1'b0}}, // down from 3
            '{CMD_LOAD,   16'h0000, 1'b1, '{16'd2,     16'd1,     1'b0}}, // zero is not prime
            '{CMD_LOAD,   16'h0001, 1'b1, '{16'd1,     16'd1,     1'b0}},
            '{CMD_LOAD,   16'h0002, 1'b1, '{16'd1,     16'd2,     1'b0}},
            '{CMD_LOAD,   16'hFFFF, 1'b1, '{16'd2,     16'd1,     1'b0}},
            '{CMD_LOAD,   16'd65521, 1'b1, '{16'd1,    16'd65521, 1'b0}}, // top prime
            '{CMD_NEXT,   16'h0000, 1'b1, '{16'd65521, 16'd65521, 1'b1}}, // overflow
            '{CMD_UNUSED, 16'hFFFF, 1'b1, '{16'd65521, 16'd65521, 1'b0}},
            '{CMD_PREV,   16'h0000, 1'b1, '{16'd65521, 16'd65519, 1'b0}},
            '{CMD_NEXT,   16'h0000, 1'b1, '{16'd65519, 16'd65521, 1'b0}},
            '{CMD_LOAD,   16'h0004, 1'b1, '{16'd65521, 16'd1,     1'b0}},
            '{CMD_NEXT,   16'h0000, 1'b1, '{16'd1,     16'd2,     1'b0}}, // up from 1
            '{CMD_LOAD,   16'd97,   1'b0, '0},
            '{CMD_NEXT,   16'h0000, 1'b0, '0},
            '{CMD_PREV,   16'h0000, 1'b0, '0},
            '{CMD_LOAD,   16'hAAAA, 1'b0, '0},
            '{CMD_LOAD,   16'h5555, 1'b0, '0},
            '{CMD_PREV,   16'h8000, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIRECTED_N; i++)
        begin
            item.command    = directed_rows[i].command;
            item.load_value = directed_rows[i].load_value;
            drive_command(item, directed_rows[i].typed, directed_rows[i].answer);
        end

        // Random part. Loads stay mostly small, since steps near the top of
        // the range are the slowest; a few land right below 2^16 so that
        // steps up run into overflow.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            tail_quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                item.command = CMD_LOAD;
            else if (pick < 65)
                item.command = CMD_NEXT;
            else if (pick < 90)
                item.command = CMD_PREV;
            else
                item.command = CMD_UNUSED;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                item.load_value = FIELD_W'($urandom_range(0, 1023));
            else if (pick < 9)
                item.load_value = FIELD_W'($urandom_range(0, 65535));
            else
                item.load_value = FIELD_W'($urandom_range(65400, 65535));
            drive_command(item, 1'b0, '0);
        end
        cmd_ch.valid <= 1'b0;

        // Drain, then a short quiet spell to catch any stray result.
        while (step_answers.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS prime_step_register");
        else
            $display("FAIL prime_step_register");
        $finish;
    end

endmodule
